### rtl/assert_macros.svh
// Assertion macros for the synapse update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at an edge implies consequent at the same edge
`define TSU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent true at an edge implies consequent at the next edge
`define TSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tsu_pkg.sv
// Shared types and constants of the trace STDP synapse update block
`default_nettype none

package tsu_pkg;

  localparam int TAU_TICKS_DEF   = 10;
  localparam int DECAY_DEPTH_DEF = 256;

  localparam int TRACE_W  = 24;
  localparam int GAIN_W   = 17;
  localparam int WEIGHT_W = 32;
  localparam int TIME_W   = 32;
  localparam int ROM_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TRACE_W-1:0]  PRE_INC_RST  = 24'd65536;
  localparam logic [TRACE_W-1:0]  POST_INC_RST = 24'd65536;
  localparam logic [GAIN_W-1:0]   POT_GAIN_RST = 17'd65536;
  localparam logic [GAIN_W-1:0]   DEP_GAIN_RST = 17'd65536;
  localparam logic [WEIGHT_W-1:0] INIT_WEIGHT_RST = 32'd65536;

  localparam logic REQ_PRE  = 1'b0;
  localparam logic REQ_POST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_INC     = 3'd0,
    CFG_POST_INC    = 3'd1,
    CFG_POT_GAIN    = 3'd2,
    CFG_DEP_GAIN    = 3'd3,
    CFG_INIT_WEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] spike_time;
  } in_req_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] new_weight;
    logic        [TRACE_W-1:0]  new_trace;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DECAY,
    ST_TRACE,
    ST_MUL_GAIN,
    ST_WEIGHT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_decay;
    logic trace_upd;
    logic mul_gain;
    logic weight_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/tsu_ctrl.sv
// Sequencing state machine of the synapse update block
`default_nettype none

module tsu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output tsu_pkg::dp_cmd_t     cmd,
  input  wire tsu_pkg::dp_sts_t sts
);
  import tsu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL_DECAY;
        end
      end
      ST_MUL_DECAY: state_nxt = ST_TRACE;
      ST_TRACE:     state_nxt = ST_MUL_GAIN;
      ST_MUL_GAIN:  state_nxt = ST_WEIGHT;
      ST_WEIGHT: begin
        // hold until the result register is free
        if (!sts.out_blocked) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_MUL_DECAY: cmd.mul_decay = 1'b1;
      ST_TRACE:     cmd.trace_upd = 1'b1;
      ST_MUL_GAIN:  cmd.mul_gain  = 1'b1;
      ST_WEIGHT:    cmd.weight_upd = !sts.out_blocked;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/tsu_dp.sv
// Datapath of the synapse update block: registers, decay ROM, shared multiplier
`default_nettype none

module tsu_dp #(
  parameter int TAU_TICKS   = tsu_pkg::TAU_TICKS_DEF,
  parameter int DECAY_DEPTH = tsu_pkg::DECAY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tsu_pkg::dp_cmd_t                 cmd,
  output tsu_pkg::dp_sts_t                      sts,
  input  wire tsu_pkg::in_req_t                 in_req,
  input  wire logic                             cfg_we,
  input  wire logic [tsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tsu_pkg::out_rsp_t                     out_rsp
);
  import tsu_pkg::*;

  localparam int IDX_W    = $clog2(DECAY_DEPTH);
  localparam int ROM_BITS = DECAY_DEPTH * ROM_W;
  localparam logic [TIME_W-1:0] LAST_IDX = TIME_W'(DECAY_DEPTH - 1);
  localparam int PROD_W   = TRACE_W + GAIN_W;

  // Restoring divider, used only while building the table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-i/TAU) in Q0.16: series for exp(-1/TAU), then repeated products
  function automatic logic [ROM_BITS-1:0] build_rom();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    logic [95:0] p;
    logic [95:0] e;
    logic [ROM_BITS-1:0] rom;
    term = 64'd1 << 40;
    sum  = term;
    rom  = '0;
    for (int k = 1; k < 24; k++) begin
      term = udiv64(term, 64'(k) * 64'(TAU_TICKS));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + 64'd128) >> 8;
    p = 96'd1 << 32;
    for (int i = 0; i < DECAY_DEPTH; i++) begin
      if (i > 0) begin
        p = (p * {32'd0, q} + (96'd1 << 31)) >> 32;
      end
      e = (p + 96'd32768) >> 16;
      rom[i*ROM_W +: ROM_W] = (e > 96'd65535) ? 16'hFFFF : e[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] DECAY_ROM = build_rom();

  // Configuration
  logic [TRACE_W-1:0]  pre_inc_r, post_inc_r;
  logic [GAIN_W-1:0]   pot_gain_r, dep_gain_r;

  // Synapse state
  logic [TRACE_W-1:0]         pre_trace_r, post_trace_r;
  logic [TIME_W-1:0]          last_pre_r, last_post_r;
  logic signed [WEIGHT_W-1:0] weight_r;

  // Per-request working registers
  logic               kind_r;
  logic [TIME_W-1:0]  time_r;
  logic [ROM_W-1:0]   rom_q_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  out_rsp_t           out_rsp_r;

  logic [TIME_W-1:0]  dt;
  logic [IDX_W-1:0]   rom_idx;
  logic [TRACE_W-1:0] sel_trace;
  logic [TRACE_W-1:0] sel_inc;
  logic [GAIN_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W:0]    rnd_sum;
  logic [PROD_W-16:0] rnd_q;
  logic [PROD_W-15:0] trace_sum;
  logic [TRACE_W-1:0] trace_nxt;
  logic signed [WEIGHT_W+1:0] w_ext;
  logic signed [WEIGHT_W+1:0] w_sum;
  logic signed [WEIGHT_W-1:0] weight_nxt;

  assign dt = in_req.spike_time - ((in_req.req_type == REQ_POST) ? last_post_r : last_pre_r);
  assign rom_idx = (dt >= LAST_IDX) ? LAST_IDX[IDX_W-1:0] : dt[IDX_W-1:0];

  assign sel_trace = (kind_r == REQ_POST) ? post_trace_r : pre_trace_r;
  assign sel_inc   = (kind_r == REQ_POST) ? post_inc_r : pre_inc_r;

  // One multiplier: trace by decay factor, then trace by gain
  always_comb begin
    if (cmd.mul_gain) begin
      mul_b = (kind_r == REQ_POST) ? dep_gain_r : pot_gain_r;
    end else begin
      mul_b = {1'b0, rom_q_r};
    end
  end
  assign mul_p = PROD_W'(sel_trace) * PROD_W'(mul_b);

  // Round Q.32 or Q.16-scaled products back by 16 bits
  assign rnd_sum   = {1'b0, prod_r} + (PROD_W+1)'(32768);
  assign rnd_q     = rnd_sum[PROD_W:16];
  assign trace_sum = {1'b0, rnd_q} + (PROD_W-14)'(sel_inc);
  assign trace_nxt = (trace_sum > (PROD_W-14)'(24'hFFFFFF)) ? 24'hFFFFFF
                                                            : trace_sum[TRACE_W-1:0];

  assign w_ext = (WEIGHT_W+2)'(weight_r);
  always_comb begin
    if (kind_r == REQ_POST) begin
      w_sum = w_ext - $signed({8'd0, rnd_q});
    end else begin
      w_sum = w_ext + $signed({8'd0, rnd_q});
    end
    if (w_sum > (WEIGHT_W+2)'(signed'(32'sh7FFFFFFF))) begin
      weight_nxt = 32'sh7FFFFFFF;
    end else if (w_sum < (WEIGHT_W+2)'(signed'(32'sh80000000))) begin
      weight_nxt = 32'sh80000000;
    end else begin
      weight_nxt = w_sum[WEIGHT_W-1:0];
    end
  end

  // Configuration registers and weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_inc_r     <= PRE_INC_RST;
      post_inc_r    <= POST_INC_RST;
      pot_gain_r    <= POT_GAIN_RST;
      dep_gain_r    <= DEP_GAIN_RST;
      weight_r      <= signed'(INIT_WEIGHT_RST);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRE_INC:  pre_inc_r  <= cfg_wdata[TRACE_W-1:0];
          CFG_POST_INC: post_inc_r <= cfg_wdata[TRACE_W-1:0];
          CFG_POT_GAIN: pot_gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_DEP_GAIN: dep_gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_INIT_WEIGHT: begin
            weight_r      <= signed'(cfg_wdata[WEIGHT_W-1:0]);
          end
          default: ;
        endcase
      end else if (cmd.weight_upd) begin
        weight_r <= weight_nxt;
      end
    end
  end

  // Traces and last spike times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_trace_r  <= '0;
      post_trace_r <= '0;
      last_pre_r   <= '0;
      last_post_r  <= '0;
    end else if (cmd.trace_upd) begin
      if (kind_r == REQ_POST) begin
        post_trace_r <= trace_nxt;
        last_post_r  <= time_r;
      end else begin
        pre_trace_r <= trace_nxt;
        last_pre_r  <= time_r;
      end
    end
  end

  // Request capture, ROM read and product register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_req.req_type;
      time_r  <= in_req.spike_time;
      rom_q_r <= DECAY_ROM[rom_idx*ROM_W +: ROM_W];
    end
    if (cmd.mul_decay || cmd.mul_gain) begin
      prod_r <= mul_p;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.weight_upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.weight_upd) begin
      out_rsp_r.new_weight <= weight_nxt;
      out_rsp_r.new_trace  <= sel_trace;
    end
  end

  assign sts.out_blocked = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_rsp         = out_rsp_r;

endmodule

`default_nettype wire

### rtl/trace_stdp_synapse_update_top.sv
// Top level of the trace based STDP synapse update block
//
// Each request is one pre or post spike with a tick time. The matching trace
// is decayed through a registered exp(-dt/TAU_TICKS) ROM read, bumped by its
// increment and saturated; the weight then moves by gain times that trace,
// up for a pre spike and down for a post spike, saturated to signed 32 bits.
// One request is in work at a time. The ROM is read at acceptance; decay
// multiply, trace update, gain multiply and weight update follow, so the
// result register is loaded in the weight update step, after which the block
// returns to idle and can take the next request. The two multiplies share
// one 24x17 multiplier. The result register lets the next request be
// accepted while a result still waits; a stalled result holds the block in
// its last step. Configuration writes take effect at once; writing
// initial_weight also reloads the weight.
`default_nettype none

`include "assert_macros.svh"

module trace_stdp_synapse_update_top #(
  parameter int TAU_TICKS   = tsu_pkg::TAU_TICKS_DEF,
  parameter int DECAY_DEPTH = tsu_pkg::DECAY_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tsu_pkg::in_req_t               in_req,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tsu_pkg::out_rsp_t                   out_rsp,
  input  wire logic                           cfg_we,
  input  wire logic [tsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  tsu_dp #(
    .TAU_TICKS   (TAU_TICKS),
    .DECAY_DEPTH (DECAY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  `TSU_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && !in_stall, in_stall, "request accepted while busy")
  `TSU_ASSERT_NEXT(a_result_lands, clk, rst_n, cmd.weight_upd, out_valid, "weight update gave no result")
  `TSU_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.weight_upd, !(out_valid && out_stall), "waiting result overwritten")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the trace based STDP synapse update block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tsu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PER_PHASE   = 210;
  localparam int SETTLE      = 8;
  localparam int MAX_LINES   = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam longint WEIGHT_MAX = 64'sh7FFF_FFFF;
  localparam longint WEIGHT_MIN = -64'sh8000_0000;

  // Tracks traces, spike times and weight; holds the updates still owed by the block
  class stdp_weight_tracker;
    int errors;
    int updates_seen;
    logic [ROM_W-1:0]    decay_rom [DECAY_DEPTH_DEF];
    logic [TRACE_W-1:0]  pre_inc, post_inc;
    logic [GAIN_W-1:0]   pot_gain, dep_gain;
    logic [TRACE_W-1:0]  pre_trace, post_trace;
    logic [TIME_W-1:0]   last_pre, last_post;
    longint              weight;
    out_rsp_t            expected_updates[$];

    function new();
      longint unsigned term, sum, q, p, e;
      term = 64'd1 << 40;
      sum = term;
      for (int k = 1; k < 24; k++) begin
        term = term / 64'(k * TAU_TICKS_DEF);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      q = (sum + 64'd128) >> 8;
      p = 64'd1 << 32;
      for (int i = 0; i < DECAY_DEPTH_DEF; i++) begin
        if (i > 0) p = (p * q + (64'd1 << 31)) >> 32;
        e = (p + 64'd32768) >> 16;
        decay_rom[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      end
      pre_inc = PRE_INC_RST;
      post_inc = POST_INC_RST;
      pot_gain = POT_GAIN_RST;
      dep_gain = DEP_GAIN_RST;
      weight = longint'($signed(INIT_WEIGHT_RST));
      pre_trace = '0;
      post_trace = '0;
      last_pre = '0;
      last_post = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PRE_INC:     pre_inc = val[TRACE_W-1:0];
        CFG_POST_INC:    post_inc = val[TRACE_W-1:0];
        CFG_POT_GAIN:    pot_gain = val[GAIN_W-1:0];
        CFG_DEP_GAIN:    dep_gain = val[GAIN_W-1:0];
        CFG_INIT_WEIGHT: weight = longint'($signed(val));
        default: ;
      endcase
    endfunction

    // Decay by the table entry for the elapsed ticks, then add the increment
    function logic [TRACE_W-1:0] decay_and_bump(logic [TRACE_W-1:0] trace,
        logic [TIME_W-1:0] last, logic [TIME_W-1:0] now, logic [TRACE_W-1:0] inc);
      logic [TIME_W-1:0] dt;
      int unsigned slot;
      longint unsigned acc;
      dt = now - last;
      slot = (dt >= 32'(DECAY_DEPTH_DEF - 1)) ? DECAY_DEPTH_DEF - 1 : dt;
      acc = (64'(trace) * 64'(decay_rom[slot]) + 64'd32768) >> 16;
      acc = acc + 64'(inc);
      return (acc > 64'hFF_FFFF) ? '1 : TRACE_W'(acc);
    endfunction

    function void move_weight(logic [GAIN_W-1:0] gain, logic [TRACE_W-1:0] trace,
        bit down);
      longint unsigned prod;
      longint w;
      prod = (64'(gain) * 64'(trace) + 64'd32768) >> 16;
      w = down ? weight - longint'(prod) : weight + longint'(prod);
      if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      else if (w < WEIGHT_MIN) w = WEIGHT_MIN;
      weight = w;
    endfunction

    function void note_spike(in_req_t req);
      out_rsp_t upd;
      if (req.req_type == REQ_PRE) begin
        pre_trace = decay_and_bump(pre_trace, last_pre, req.spike_time, pre_inc);
        last_pre = req.spike_time;
        move_weight(pot_gain, pre_trace, 1'b0);
        upd.new_trace = pre_trace;
      end else begin
        post_trace = decay_and_bump(post_trace, last_post, req.spike_time, post_inc);
        last_post = req.spike_time;
        move_weight(dep_gain, post_trace, 1'b1);
        upd.new_trace = post_trace;
      end
      upd.new_weight = 32'(weight);
      expected_updates.push_back(upd);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_LINES) $display("mismatch at update %0d: %s", updates_seen, msg);
    endtask

    task check_update(out_rsp_t got);
      out_rsp_t want;
      if (expected_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected update, weight %0d trace %0d",
                                  got.new_weight, got.new_trace));
      end else begin
        want = expected_updates.pop_front();
        if (got.new_weight !== want.new_weight)
          report_mismatch($sformatf("new_weight %0d, expected %0d",
                                    got.new_weight, want.new_weight));
        if (got.new_trace !== want.new_trace)
          report_mismatch($sformatf("new_trace %0d, expected %0d",
                                    got.new_trace, want.new_trace));
      end
      updates_seen++;
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stdp_weight_tracker tracker;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [TIME_W-1:0] spike_clock = '0;
  logic burst_kind = REQ_PRE;

  trace_stdp_synapse_update_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Check the result first: it always belongs to an earlier request
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && !out_stall) tracker.check_update(out_rsp);
      if (in_valid && !in_stall) tracker.note_spike(in_req);
    end
  end

  // Idle for a random gap, then hold the request until it is taken
  task automatic spike(logic kind, logic [TIME_W-1:0] t);
    in_req_t req;
    int gap;
    req.req_type = kind;
    req.spike_time = t;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Step one edge first so the last accepted request is already noted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Upper bits of narrow registers carry whatever the caller passes; they must be dropped
  task automatic apply_settings(logic [31:0] pre_i, logic [31:0] post_i,
      logic [31:0] pot, logic [31:0] dep, logic [31:0] w);
    cfg_write(CFG_SPARE_IDX, $urandom());
    cfg_write(CFG_PRE_INC, pre_i);
    cfg_write(CFG_POST_INC, post_i);
    cfg_write(CFG_POT_GAIN, pot);
    cfg_write(CFG_DEP_GAIN, dep);
    cfg_write(CFG_INIT_WEIGHT, w);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short forward steps so traces build up; some same tick, long, wild and backward
  function automatic logic [TIME_W-1:0] next_spike_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) spike_clock = spike_clock + $urandom_range(1, 30);
    else if (pick < 72) spike_clock = spike_clock;
    else if (pick < 82) spike_clock = spike_clock + $urandom_range(31, 400);
    else if (pick < 88) spike_clock = $urandom();
    else if (pick < 95) spike_clock = spike_clock - $urandom_range(1, 50);
    else spike_clock = 32'hFFFF_FFFF - $urandom_range(0, 20);
    return spike_clock;
  endfunction

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: same tick, table edges, backwards time, wrap
    spike(REQ_PRE, 32'd0);
    spike(REQ_PRE, 32'd0);
    spike(REQ_POST, 32'd0);
    spike(REQ_PRE, 32'd1);
    spike(REQ_PRE, 32'd11);
    spike(REQ_PRE, 32'd265);
    spike(REQ_PRE, 32'd520);
    spike(REQ_POST, 32'd256);
    spike(REQ_POST, 32'd300);
    spike(REQ_POST, 32'd200);
    spike(REQ_PRE, 32'hFFFF_FFFF);
    spike(REQ_PRE, 32'd0);
    spike(REQ_POST, 32'hFFFF_FFFF);

    // Half-unit trace kept exactly on a same tick; weight hits the top
    drain();
    apply_settings(32'd32768, 32'hFFFF_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'h7FFF_FF00);
    spike(REQ_PRE, 32'd2000);
    spike(REQ_PRE, 32'd2000);
    spike(REQ_PRE, 32'd2001);
    spike(REQ_POST, 32'd2000);

    // Weight hits the bottom; zero increment and zero gain
    drain();
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h1_FFFF, 32'h8000_0100);
    spike(REQ_POST, 32'd2000);
    spike(REQ_POST, 32'd2000);
    spike(REQ_POST, 32'd2010);
    spike(REQ_PRE, 32'd5000);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: apply_settings(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
        1: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'd0);
        2: apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        4: apply_settings($urandom_range(0, 32'h3_FFFF), $urandom_range(0, 32'h3_FFFF),
                          $urandom(), $urandom(), 32'h8000_0000);
        6: apply_settings(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h1_FFFF, $urandom());
        default: apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      repeat (PER_PHASE) begin
        if ($urandom_range(99) < 30) burst_kind = ~burst_kind;
        spike(burst_kind, next_spike_time());
      end
    end

    drain();
    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### trace_stdp_synapse_update_top.f
+incdir+rtl
rtl/tsu_pkg.sv
rtl/tsu_ctrl.sv
rtl/tsu_dp.sv
rtl/trace_stdp_synapse_update_top.sv
test/testbench.sv
